### design/factor_counter_two_three_five_defines.svh
// Assertion macros used by the top-level design file.
`ifndef FACTOR_COUNTER_TWO_THREE_FIVE_DEFINES_SVH
`define FACTOR_COUNTER_TWO_THREE_FIVE_DEFINES_SVH

// Concurrent check on clk_i, switched off while rst_ni is low.
`define FC235_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define FC235_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/fc235_pkg.sv
package fc235_pkg;

  // Width of the value and cofactor words.
  localparam int unsigned DATA_WIDTH = 32;
  // Width of each exponent counter.
  localparam int unsigned COUNT_WIDTH = 16;

  // Odd divisor tried by the shared multiply unit.
  typedef enum logic {
    DIV_THREE,
    DIV_FIVE
  } divisor_e;

  // Answer of the shared unit.
  typedef struct packed {
    logic                  divisible;
    logic [DATA_WIDTH-1:0] quotient;
  } div_res_t;

endpackage

### design/fc235_in_if.sv
// Input channel: one word is a clear flag and a value to factor.
interface fc235_in_if import fc235_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         clear_first;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, clear_first, value, input ready);
  modport sink (input valid, clear_first, value, output ready);
endinterface

### design/fc235_out_if.sv
// Output channel: one word carries the totals, the cofactor and two flags.
interface fc235_out_if import fc235_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [COUNT_WIDTH-1:0]       total_twos;
  logic [COUNT_WIDTH-1:0]       total_threes;
  logic [COUNT_WIDTH-1:0]       total_fives;
  logic signed [DATA_WIDTH-1:0] cofactor;
  logic                         input_was_zero;
  logic                         fully_smooth;

  modport source (
    output valid, total_twos, total_threes, total_fives, cofactor, input_was_zero,
           fully_smooth,
    input  ready
  );
  modport sink (
    input  valid, total_twos, total_threes, total_fives, cofactor, input_was_zero,
           fully_smooth,
    output ready
  );
endinterface

### design/fc235_div_unit.sv
// Exact division test by three or five with one shared multiplier.
// An unsigned word x is a multiple of an odd d exactly when x times the
// inverse of d modulo 2**DATA_WIDTH is no larger than (2**DATA_WIDTH-1)/d,
// and that product is then the quotient itself.
module fc235_div_unit import fc235_pkg::*; (
  input  logic [DATA_WIDTH-1:0] operand_i,
  input  divisor_e              sel_i,
  output div_res_t              res_o
);

  // Newton iteration for the inverse of an odd number modulo the word size.
  // The start value is right to three bits; six rounds cover 64 bits.
  function automatic logic [DATA_WIDTH-1:0] mul_inverse(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH-1:0] x;
    x = d;
    for (int i = 0; i < 6; i++) begin
      x = x * (DATA_WIDTH'(2) - d * x);
    end
    return x;
  endfunction

  localparam logic [DATA_WIDTH-1:0] DataMax = '1;
  localparam logic [DATA_WIDTH-1:0] Inv3    = mul_inverse(DATA_WIDTH'(3));
  localparam logic [DATA_WIDTH-1:0] Inv5    = mul_inverse(DATA_WIDTH'(5));
  localparam logic [DATA_WIDTH-1:0] Lim3    = DataMax / 3;
  localparam logic [DATA_WIDTH-1:0] Lim5    = DataMax / 5;

  logic [DATA_WIDTH-1:0] inv;
  logic [DATA_WIDTH-1:0] lim;
  logic [DATA_WIDTH-1:0] product;

  // Pick the constants for the divisor under test.
  always_comb begin
    unique case (sel_i)
      DIV_THREE: begin
        inv = Inv3;
        lim = Lim3;
      end
      DIV_FIVE: begin
        inv = Inv5;
        lim = Lim5;
      end
      default: begin
        inv = Inv3;
        lim = Lim3;
      end
    endcase
  end

  // Product kept to the word size, then the range compare.
  assign product         = operand_i * inv;
  assign res_o.quotient  = product;
  assign res_o.divisible = (product <= lim);

endmodule

### design/factor_counter_two_three_five.sv
// Trial division of a signed word by 2, 3 and 5 with saturating running
// exponent counters. A word is taken only while the sequencer is idle; the
// sequencer then removes one factor per step: a factor of two by a shift, a
// factor of three by the evenness test and then the shared multiplier, a
// factor of five by the evenness test, the failed test by three and then the
// test by five, and the final failing tests are followed by the hand-over.
// Zero and negative values go straight to the hand-over. The single multiplier
// in the division unit is used at most once per step. The result sits in an
// output register, so the next word is accepted while a finished result waits;
// a word only finishes once that register is free or being emptied.
// clear_first zeroes the counters at the moment the word is accepted.
`include "factor_counter_two_three_five_defines.svh"

module factor_counter_two_three_five import fc235_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fc235_in_if.sink    in_i,
  fc235_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWO,
    S_THREE,
    S_FIVE,
    S_FIN
  } state_e;

  // Counter step that holds at the all-ones value.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  state_e                 state_q, state_d;
  logic [DATA_WIDTH-1:0]  rest_q, rest_d;
  logic                   zero_q, zero_d;
  logic [COUNT_WIDTH-1:0] twos_q, twos_d;
  logic [COUNT_WIDTH-1:0] threes_q, threes_d;
  logic [COUNT_WIDTH-1:0] fives_q, fives_d;

  logic                   out_valid_q, out_valid_d;
  logic [COUNT_WIDTH-1:0] out_twos_q, out_twos_d;
  logic [COUNT_WIDTH-1:0] out_threes_q, out_threes_d;
  logic [COUNT_WIDTH-1:0] out_fives_q, out_fives_d;
  logic [DATA_WIDTH-1:0]  out_cof_q, out_cof_d;
  logic                   out_zero_q, out_zero_d;
  logic                   out_smooth_q, out_smooth_d;

  divisor_e               div_sel;
  div_res_t               div_res;

  // Shared divide-by-three-or-five unit.
  assign div_sel = (state_q == S_FIVE) ? DIV_FIVE : DIV_THREE;

  fc235_div_unit u_div (
    .operand_i (rest_q),
    .sel_i     (div_sel),
    .res_o     (div_res)
  );

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer and output register next-state logic.
  always_comb begin
    state_d      = state_q;
    rest_d       = rest_q;
    zero_d       = zero_q;
    twos_d       = twos_q;
    threes_d     = threes_q;
    fives_d      = fives_q;
    out_valid_d  = out_valid_q;
    out_twos_d   = out_twos_q;
    out_threes_d = out_threes_q;
    out_fives_d  = out_fives_q;
    out_cof_d    = out_cof_q;
    out_zero_d   = out_zero_q;
    out_smooth_d = out_smooth_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rest_d = in_i.value;
          zero_d = (in_i.value == '0);
          if (in_i.clear_first) begin
            twos_d   = '0;
            threes_d = '0;
            fives_d  = '0;
          end
          // Zero and negative words are passed through untouched.
          if (in_i.value[DATA_WIDTH-1] || (in_i.value == '0)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_TWO;
          end
        end
      end
      S_TWO: begin
        if (!rest_q[0]) begin
          rest_d = rest_q >> 1;
          twos_d = sat_inc(twos_q);
        end else begin
          state_d = S_THREE;
        end
      end
      S_THREE: begin
        if (div_res.divisible) begin
          rest_d   = div_res.quotient;
          threes_d = sat_inc(threes_q);
          state_d  = S_TWO;
        end else begin
          state_d = S_FIVE;
        end
      end
      S_FIVE: begin
        if (div_res.divisible) begin
          rest_d  = div_res.quotient;
          fives_d = sat_inc(fives_q);
          state_d = S_TWO;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_twos_d   = twos_q;
          out_threes_d = threes_q;
          out_fives_d  = fives_q;
          out_cof_d    = rest_q;
          out_zero_d   = zero_q;
          out_smooth_d = (rest_q == DATA_WIDTH'(1));
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rest_q       <= '0;
      zero_q       <= 1'b0;
      twos_q       <= '0;
      threes_q     <= '0;
      fives_q      <= '0;
      out_valid_q  <= 1'b0;
      out_twos_q   <= '0;
      out_threes_q <= '0;
      out_fives_q  <= '0;
      out_cof_q    <= '0;
      out_zero_q   <= 1'b0;
      out_smooth_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      rest_q       <= rest_d;
      zero_q       <= zero_d;
      twos_q       <= twos_d;
      threes_q     <= threes_d;
      fives_q      <= fives_d;
      out_valid_q  <= out_valid_d;
      out_twos_q   <= out_twos_d;
      out_threes_q <= out_threes_d;
      out_fives_q  <= out_fives_d;
      out_cof_q    <= out_cof_d;
      out_zero_q   <= out_zero_d;
      out_smooth_q <= out_smooth_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.total_twos     = out_twos_q;
  assign out_o.total_threes   = out_threes_q;
  assign out_o.total_fives    = out_fives_q;
  assign out_o.cofactor       = out_cof_q;
  assign out_o.input_was_zero = out_zero_q;
  assign out_o.fully_smooth   = out_smooth_q;

  // While factoring, the remainder is always a positive number.
  `FC235_ASSERT(a_rest_positive, (state_q == S_TWO || state_q == S_THREE || state_q == S_FIVE) |-> (rest_q != '0 && !rest_q[DATA_WIDTH-1]), "remainder left the positive range during factoring")

  // An even remainder is halved in the very next cycle.
  `FC235_ASSERT(a_halving, (state_q == S_TWO && !rest_q[0]) |=> (rest_q == ($past(rest_q) >> 1)), "even remainder was not halved")

  // A clearing word leaves all three counters at zero right after it is taken.
  `FC235_ASSERT(a_clear, (in_i.valid && in_i.ready && in_i.clear_first) |=> (twos_q == '0 && threes_q == '0 && fives_q == '0), "counters not cleared on a clearing word")

  // A smooth result is a cofactor of one from a non-zero word.
  `FC235_ASSERT_ALWAYS(a_smooth, (out_valid_q && out_smooth_q) |-> (out_cof_q == DATA_WIDTH'(1) && !out_zero_q), "smooth flag without a cofactor of one")

endmodule
